FILE: rtl/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;

    // table geometry
    localparam int ADDR_WIDTH   = 16;
    localparam int MAX_SEGMENTS = 64;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]                        opcode;
        logic [ADDR_WIDTH:0]               alloc_len;
        logic [ADDR_WIDTH-1:0]             seg_start;
        logic [ADDR_WIDTH:0]               seg_size;
        logic [$clog2(MAX_SEGMENTS)-1:0]   entry_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                        status;
        logic [ADDR_WIDTH-1:0]             result_start;
        logic [ADDR_WIDTH:0]               result_size;
        logic [$clog2(MAX_SEGMENTS+1)-1:0] free_count;
    } out_word_t;

endpackage

FILE: rtl/first_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// First-fit free segment allocator with coalescing.
// in  channel (in_valid/in_ready/in_data): one command word: allocate, release
//     or read entry; opcode 3 is a no-op.
// out channel (out_valid/out_ready/out_data): one result word per command:
//     status, granted or read start, read size, segment count after the op.
// The table (start, size) lives in one simple dual-port synchronous memory
// with a registered read; every change is a read-modify-write by a sequencer.
// A no-op or a zero-size release goes straight to the result; a read first
// fetches the entry. Allocate and release scan the entries in order and may
// then shift entries down or up to close or open a slot.
// One command is in flight at a time. The result sits in an output register;
// the next command is taken the cycle after that register is handed over, so
// a stalled receiver holds the result and blocks only the next command.
// Reset clears the segment count and the control state; table contents are
// left as they are and are never read before being written.
module first_fit_free_list_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffa_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ffa_pkg::out_word_t  out_data
);

    localparam int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS;
    localparam int ADDR_WIDTH   = ffa_pkg::ADDR_WIDTH;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SW = ADDR_WIDTH + 1;
    localparam int EW = ADDR_WIDTH + SW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;   // issue read of pos_reg
    localparam logic [3:0] S_SCANW = 4'd2;   // examine read data
    localparam logic [3:0] S_PRED  = 4'd3;   // read predecessor
    localparam logic [3:0] S_PREDW = 4'd4;
    localparam logic [3:0] S_DECR  = 4'd5;   // release merge decision
    localparam logic [3:0] S_SHD   = 4'd6;   // shift down: read k+1
    localparam logic [3:0] S_SHDW  = 4'd7;   // write k
    localparam logic [3:0] S_SHU   = 4'd8;   // shift up: read k-1
    localparam logic [3:0] S_SHUW  = 4'd9;   // write k
    localparam logic [3:0] S_RDW   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // table memory: {start, size}
    logic [EW-1:0] mem [MAX_SEGMENTS];
    logic [EW-1:0] rdata_reg;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    logic [ADDR_WIDTH-1:0] rd_start;
    logic [SW-1:0]         rd_size;
    assign rd_start = rdata_reg[EW-1:SW];
    assign rd_size  = rdata_reg[SW-1:0];

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       pos_reg, pos_next;     // scan / shift index
    logic [CW-1:0]       stop_reg, stop_next;   // shift end index
    ffa_pkg::in_word_t   cmd_reg, cmd_next;
    logic [EW-1:0]       succ_reg, succ_next;   // entry at insert point
    logic                succ_ok_reg, succ_ok_next;
    logic                out_valid_reg, out_valid_next;
    ffa_pkg::out_word_t  res_reg, res_next;

    logic [ADDR_WIDTH-1:0] cmd_st;
    logic [SW-1:0]         cmd_sz, cmd_req;
    assign cmd_st  = cmd_reg.seg_start;
    assign cmd_sz  = cmd_reg.seg_size;
    assign cmd_req = cmd_reg.alloc_len;

    // saturating add of up to three sizes
    function automatic logic [SW-1:0] sat3(input logic [SW-1:0] a,
                                           input logic [SW-1:0] b,
                                           input logic [SW-1:0] c);
        logic [SW+1:0] s;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c};
        return (s[SW+1:SW] != 2'b0) ? {SW{1'b1}} : s[SW-1:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    logic [SW:0] pred_end;
    logic [SW:0] new_end;
    assign pred_end = {1'b0, SW'(rd_start)} + {1'b0, rd_size};
    assign new_end  = {1'b0, SW'(cmd_st)} + {1'b0, cmd_sz};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        stop_next      = stop_reg;
        cmd_next       = cmd_reg;
        succ_next      = succ_reg;
        succ_ok_next   = succ_ok_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        we    = 1'b0;
        waddr = pos_reg[IW-1:0];
        wdata = '0;
        raddr = pos_reg[IW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next = in_data;
                    pos_next = '0;
                    res_next = '0;
                    case (in_data.opcode)
                        ffa_pkg::OP_ALLOC:   state_next = S_SCAN;
                        ffa_pkg::OP_RELEASE:
                        begin
                            if (in_data.seg_size == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ffa_pkg::OP_READ:
                        begin
                            if (CW'(in_data.entry_index) < count_reg)
                            begin
                                raddr      = in_data.entry_index;
                                state_next = S_RDW;
                            end
                            else
                            begin
                                res_next.status = ffa_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            S_RDW:
            begin
                res_next.result_start = rd_start;
                res_next.result_size  = rd_size;
                state_next            = S_DONE;
            end

            S_SCAN:
            begin
                if (pos_reg >= count_reg)
                begin
                    if (cmd_reg.opcode == ffa_pkg::OP_ALLOC)
                    begin
                        res_next.status = ffa_pkg::ST_NOFIT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        succ_ok_next = 1'b0;
                        if (pos_reg != '0)
                        begin
                            raddr      = IW'(pos_reg - 1'b1);
                            state_next = S_PRED;
                        end
                        else
                        begin
                            state_next = S_DECR;
                        end
                    end
                end
                else
                begin
                    state_next = S_SCANW;
                end
            end

            S_SCANW:
            begin
                if (cmd_reg.opcode == ffa_pkg::OP_ALLOC)
                begin
                    if (rd_size == cmd_req)
                    begin
                        res_next.result_start = rd_start;
                        count_next = count_reg - 1'b1;
                        stop_next  = count_reg - 1'b1;
                        state_next = S_SHD;
                    end
                    else if (rd_size > cmd_req)
                    begin
                        res_next.result_start = rd_start;
                        we    = 1'b1;
                        wdata = {rd_start + cmd_req[ADDR_WIDTH-1:0], rd_size - cmd_req};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (rd_start <= cmd_st)
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        succ_next    = rdata_reg;
                        succ_ok_next = 1'b1;
                        if (pos_reg != '0)
                        begin
                            raddr      = IW'(pos_reg - 1'b1);
                            state_next = S_PRED;
                        end
                        else
                        begin
                            state_next = S_DECR;
                        end
                    end
                end
            end

            // hold the predecessor address so its data lands next cycle
            S_PRED:
            begin
                raddr      = IW'(pos_reg - 1'b1);
                state_next = S_PREDW;
            end

            // predecessor data available in S_PREDW; release merge decision for both states
            S_PREDW, S_DECR:
            begin
                logic pa, sa;
                pa = (state_reg == S_PREDW) && (pred_end == {1'b0, SW'(cmd_st)});
                sa = succ_ok_reg &&
                     (new_end == {1'b0, SW'(succ_reg[EW-1:SW])});
                if (pa && sa)
                begin
                    we    = 1'b1;
                    waddr = IW'(pos_reg - 1'b1);
                    wdata = {rd_start, sat3(rd_size, cmd_sz, succ_reg[SW-1:0])};
                    count_next = count_reg - 1'b1;
                    stop_next  = count_reg - 1'b1;
                    state_next = S_SHD;
                end
                else if (pa)
                begin
                    we    = 1'b1;
                    waddr = IW'(pos_reg - 1'b1);
                    wdata = {rd_start, sat3(rd_size, cmd_sz, '0)};
                    state_next = S_DONE;
                end
                else if (sa)
                begin
                    we    = 1'b1;
                    wdata = {cmd_st, sat3(succ_reg[SW-1:0], cmd_sz, '0)};
                    state_next = S_DONE;
                end
                else if (count_reg >= CW'(MAX_SEGMENTS))
                begin
                    res_next.status = ffa_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    // open a slot at pos by shifting up from the top
                    stop_next  = pos_reg;
                    pos_next   = count_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_SHU;
                end
            end

            S_SHD:
            begin
                if (pos_reg >= stop_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = IW'(pos_reg + 1'b1);
                    state_next = S_SHDW;
                end
            end

            S_SHDW:
            begin
                we         = 1'b1;
                wdata      = rdata_reg;
                pos_next   = pos_reg + 1'b1;
                state_next = S_SHD;
            end

            S_SHU:
            begin
                if (pos_reg <= stop_reg)
                begin
                    we         = 1'b1;
                    wdata      = {cmd_st, cmd_sz};
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = IW'(pos_reg - 1'b1);
                    state_next = S_SHUW;
                end
            end

            S_SHUW:
            begin
                we         = 1'b1;
                wdata      = rdata_reg;
                pos_next   = pos_reg - 1'b1;
                state_next = S_SHU;
            end

            S_DONE:
            begin
                res_next.free_count = count_reg;
                out_valid_next      = 1'b1;
                state_next          = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        stop_reg    <= stop_next;
        cmd_reg     <= cmd_next;
        succ_reg    <= succ_next;
        succ_ok_reg <= succ_ok_next;
        res_reg     <= res_next;
    end

endmodule

FILE: rtl/ffa_checker.sv
`timescale 1ns / 1ps
module ffa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input ffa_pkg::in_word_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input ffa_pkg::out_word_t out_data
);

    // a held result word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // no new command while a result waits
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("command taken with result pending");

    // count never exceeds table depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.free_count <= 7'd64)
        else $error("count above capacity");

    // read size is zero unless status ok
    a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ffa_pkg::ST_OK |-> out_data.result_size == '0)
        else $error("size on failed op");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);
